>>> sv/mqtt_pkg.sv
package mqtt_pkg;

  localparam int MaxLengthBytesDefault = 4;

  localparam logic [1:0] StOk         = 2'd0;
  localparam logic [1:0] StIncomplete = 2'd1;
  localparam logic [1:0] StMalformed  = 2'd2;

  localparam logic [1:0] LenDecoding  = 2'd0;
  localparam logic [1:0] LenDone      = 2'd1;
  localparam logic [1:0] LenBad       = 2'd2;

  localparam logic [2:0] KindPublish  = 3'd0;
  localparam logic [2:0] KindConnack  = 3'd1;
  localparam logic [2:0] KindSuback   = 3'd2;
  localparam logic [2:0] KindPuback   = 3'd3;
  localparam logic [2:0] KindPingresp = 3'd4;

  // Snapshot of one buffer, handed from the byte front end to the checker.
  typedef struct packed {
    logic [31:0] byte_count;
    logic [2:0]  packet_kind;
    logic [7:0]  header_byte;
    logic [27:0] length_value;
    logic [2:0]  length_byte_count;
    logic [1:0]  length_status;
    logic [7:0]  saved_byte_one;
    logic [7:0]  saved_byte_two;
    logic [7:0]  saved_byte_three;
    logic [15:0] topic_length;
    logic [15:0] ident_value;
  } snap_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        dup_flag;
    logic [1:0]  qos_level;
    logic        retain_flag;
    logic [15:0] msg_id;
    logic [2:0]  topic_offset;
    logic [15:0] topic_bytes;
    logic [16:0] body_offset;
    logic [28:0] body_len;
    logic [28:0] frame_len;
    logic        sess_flag;
    logic [7:0]  ack_code;
  } result_t;

endpackage

>>> sv/mqtt_front.sv
module mqtt_front #(
  parameter int MAX_LENGTH_BYTES = mqtt_pkg::MaxLengthBytesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [2:0]         cmd,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               snap_valid,
  output mqtt_pkg::snap_t    snap
);

  mqtt_pkg::snap_t st, st_next;
  logic [17:0] hdr_pos, pub_pos;
  logic [4:0]  sh;

  always_comb begin
    st_next = st;
    hdr_pos = 18'd1 + 18'(st.length_byte_count);
    pub_pos = hdr_pos + 18'd2 + 18'(st.topic_length);
    sh = 5'd7 * 5'(st.length_byte_count[1:0]);
    if (st.byte_count == 32'd0) begin
      st_next.packet_kind = cmd;
      st_next.header_byte = data_byte;
    end
    if (st.byte_count == 32'd1) st_next.saved_byte_one = data_byte;
    if (st.byte_count == 32'd2) st_next.saved_byte_two = data_byte;
    if (st.byte_count == 32'd3) st_next.saved_byte_three = data_byte;
    if (st.byte_count != 32'd0 && st.length_status == mqtt_pkg::LenDecoding) begin
      st_next.length_value = st.length_value | (28'(data_byte[6:0]) << sh);
      st_next.length_byte_count = st.length_byte_count + 3'd1;
      if (!data_byte[7]) begin
        st_next.length_status = mqtt_pkg::LenDone;
      end else if (32'(st_next.length_byte_count) >= 32'(MAX_LENGTH_BYTES)) begin
        st_next.length_status = mqtt_pkg::LenBad;
      end
    end else if (st.byte_count != 32'd0 && st.length_status == mqtt_pkg::LenDone) begin
      if (st.packet_kind == mqtt_pkg::KindPublish) begin
        if (st.byte_count == 32'(hdr_pos)) begin
          st_next.topic_length = {data_byte, 8'd0};
        end else if (st.byte_count == 32'(hdr_pos) + 32'd1) begin
          st_next.topic_length = st.topic_length | 16'(data_byte);
        end else if (st.byte_count == 32'(pub_pos)) begin
          st_next.ident_value = {data_byte, 8'd0};
        end else if (st.byte_count == 32'(pub_pos) + 32'd1) begin
          st_next.ident_value = st.ident_value | 16'(data_byte);
        end
      end else begin
        if (st.byte_count == 32'(hdr_pos)) begin
          st_next.ident_value = {data_byte, 8'd0};
        end else if (st.byte_count == 32'(hdr_pos) + 32'd1) begin
          st_next.ident_value = st.ident_value | 16'(data_byte);
        end
      end
    end
    if (st.byte_count != 32'hFFFF_FFFF) st_next.byte_count = st.byte_count + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= in_fire && last_byte;
      if (in_fire) st <= last_byte ? '0 : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) snap <= st_next;
  end

endmodule

>>> sv/mqtt_queue.sv
module mqtt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  mqtt_pkg::snap_t wr_data,
  output logic [1:0]      count,
  input  logic            rd_en,
  output mqtt_pkg::snap_t rd_data,
  output logic            rd_valid
);

  mqtt_pkg::snap_t mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;

  assign rd_valid = fill != 3'd0;
  assign rd_data  = mem[rd_ptr];
  assign count    = fill[2] ? 2'd3 : fill[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 2'd1;
      if (rd_en) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(wr_en) - 3'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (rst) !(fill == 3'd4 && wr_en && !rd_en))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) !(fill == 3'd0 && rd_en))
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (rst) fill <= 3'd4)
    else $error("fill out of range");

endmodule

>>> sv/mqtt_check.sv
module mqtt_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              snap_valid,
  input  mqtt_pkg::snap_t   snap,
  output logic              snap_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output mqtt_pkg::result_t res
);

  mqtt_pkg::result_t r;
  logic [33:0] rx, hdr, plen, idx, tend, rc;
  logic [1:0]  qos, le;
  logic        len_ok;

  always_comb begin
    r = '0;
    r.status = mqtt_pkg::StMalformed;
    rx   = 34'(snap.byte_count);
    hdr  = 34'd1 + 34'(snap.length_byte_count);
    plen = hdr + 34'(snap.length_value);
    idx  = hdr + 34'd2;
    tend = idx + 34'(snap.topic_length);
    rc   = plen - idx;
    qos  = snap.header_byte[2:1];
    len_ok = snap.length_status == mqtt_pkg::LenDone;
    le = (snap.length_status == mqtt_pkg::LenDecoding) ? mqtt_pkg::StIncomplete
                                                       : mqtt_pkg::StMalformed;
    case (snap.packet_kind)
      mqtt_pkg::KindPublish: begin
        if (rx < 34'd2 || snap.header_byte[7:4] != 4'h3 || qos == 2'd3) begin
          r.status = mqtt_pkg::StMalformed;
        end else if (!len_ok) begin
          r.status = le;
        end else if (rx < plen) begin
          r.status = mqtt_pkg::StIncomplete;
        end else if (idx > plen || tend > plen) begin
          r.status = mqtt_pkg::StMalformed;
        end else if (qos != 2'd0 && tend + 34'd2 > plen) begin
          // Topic fields are already reported when only the identifier is missing
          r.status       = mqtt_pkg::StMalformed;
          r.topic_offset = 3'(idx);
          r.topic_bytes  = snap.topic_length;
        end else begin
          r.status       = mqtt_pkg::StOk;
          r.topic_offset = 3'(idx);
          r.topic_bytes  = snap.topic_length;
          r.dup_flag     = snap.header_byte[3];
          r.qos_level    = qos;
          r.retain_flag  = snap.header_byte[0];
          r.msg_id       = (qos != 2'd0) ? snap.ident_value : 16'd0;
          r.body_offset  = 17'((qos != 2'd0) ? tend + 34'd2 : tend);
          r.body_len     = 29'(plen - ((qos != 2'd0) ? tend + 34'd2 : tend));
          r.frame_len    = 29'(plen);
        end
      end
      mqtt_pkg::KindConnack: begin
        if (rx < 34'd4) begin
          r.status = mqtt_pkg::StIncomplete;
        end else if (snap.header_byte != 8'h20 || snap.saved_byte_one != 8'h02 ||
                     snap.saved_byte_two[7:1] != 7'd0 ||
                     (snap.saved_byte_three != 8'd0 && snap.saved_byte_two[0])) begin
          r.status = mqtt_pkg::StMalformed;
        end else begin
          r.status    = mqtt_pkg::StOk;
          r.sess_flag = snap.saved_byte_two[0];
          r.ack_code  = snap.saved_byte_three;
        end
      end
      mqtt_pkg::KindSuback: begin
        if (rx < 34'd2) begin
          r.status = mqtt_pkg::StIncomplete;
        end else if (snap.header_byte != 8'h90) begin
          r.status = mqtt_pkg::StMalformed;
        end else if (!len_ok) begin
          r.status = le;
        end else if (rx < plen) begin
          r.status = mqtt_pkg::StIncomplete;
        end else if (snap.length_value < 28'd3 || rc == 34'd0 || rc > 34'd255) begin
          r.status = mqtt_pkg::StMalformed;
        end else begin
          r.status      = mqtt_pkg::StOk;
          r.msg_id      = snap.ident_value;
          r.body_offset = 17'(idx);
          r.body_len    = 29'(rc);
          r.frame_len   = 29'(plen);
        end
      end
      mqtt_pkg::KindPuback: begin
        if (rx < 34'd4) begin
          r.status = mqtt_pkg::StIncomplete;
        end else if (!len_ok) begin
          r.status = le;
        end else if (snap.header_byte != 8'h40 || snap.length_value != 28'd2 ||
                     snap.length_byte_count != 3'd1) begin
          r.status = mqtt_pkg::StMalformed;
        end else begin
          r.status = mqtt_pkg::StOk;
          r.msg_id = snap.ident_value;
        end
      end
      mqtt_pkg::KindPingresp: begin
        if (rx < 34'd2) begin
          r.status = mqtt_pkg::StIncomplete;
        end else if (!len_ok) begin
          r.status = le;
        end else if (snap.header_byte != 8'hD0 || snap.length_value != 28'd0 ||
                     snap.length_byte_count != 3'd1) begin
          r.status = mqtt_pkg::StMalformed;
        end else begin
          r.status = mqtt_pkg::StOk;
        end
      end
      default: r.status = mqtt_pkg::StMalformed;
    endcase
  end

  assign snap_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (snap_ready) res_valid <= snap_valid;
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) res <= r;
  end

endmodule

>>> sv/mqtt_packet_header_parser_core.sv
// A request's last byte closes its snapshot in the front end register, the snapshot is
// written into the snapshot queue, and the checker registers its result onto m_tvalid.
// Throughput: one byte per cycle; the byte front end stalls only while the snapshot
// queue holds two or more buffers.
// The checker decides one queued snapshot per cycle unless its output is stalled.
// Reset (rst, synchronous) clears the byte state, the queue and the output valid.
module mqtt_packet_header_parser_core #(
  parameter int MAX_LENGTH_BYTES = mqtt_pkg::MaxLengthBytesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,  // data_byte[7:0]
  input  logic [2:0]   s_tuser,  // cmd[2:0]
  input  logic         s_tlast,  // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], dup_flag[2], qos_level[4:3], retain_flag[5], msg_id[21:6],
  // topic_offset[24:22], topic_bytes[40:25], body_offset[57:41], body_len[86:58],
  // frame_len[115:87], sess_flag[116], ack_code[124:117], zeros
  output logic [127:0] m_tdata
);

  logic              in_fire, fsnap_valid, q_valid, q_rd, c_ready;
  logic [1:0]        q_count;
  mqtt_pkg::snap_t   fsnap, q_data;
  mqtt_pkg::result_t res;

  // Leave room for snapshots still in flight from the front end.
  assign s_tready = q_count < 2'd2;
  assign in_fire  = s_tvalid && s_tready;
  assign q_rd     = q_valid && c_ready;

  mqtt_front #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_front (
    .clk, .rst, .in_fire,
    .cmd(s_tuser), .data_byte(s_tdata), .last_byte(s_tlast),
    .snap_valid(fsnap_valid), .snap(fsnap)
  );

  mqtt_queue u_queue (
    .clk, .rst, .wr_en(fsnap_valid), .wr_data(fsnap), .count(q_count),
    .rd_en(q_rd), .rd_data(q_data), .rd_valid(q_valid)
  );

  mqtt_check u_check (
    .clk, .rst, .snap_valid(q_valid), .snap(q_data), .snap_ready(c_ready),
    .res_valid(m_tvalid), .res_ready(m_tready), .res
  );

  assign m_tdata = {3'd0, res.ack_code, res.sess_flag, res.frame_len,
                    res.body_len, res.body_offset, res.topic_bytes, res.topic_offset,
                    res.msg_id, res.retain_flag, res.qos_level, res.dup_flag,
                    res.status};

endmodule

>>> dv/testbench.sv
module testbench;

  localparam logic [31:0] ByteCap = 32'hFFFF_FFFF;

  // Expected parse results, oldest first.
  class parse_board;
    mqtt_pkg::result_t pending[$];
    int mismatches;
    int errors;

    // Parser state tracked per buffer
    logic [31:0] nbytes;
    logic [2:0]  kind;
    logic [7:0]  hdr_byte;
    logic [27:0] len_val;
    logic [2:0]  len_cnt;
    logic [1:0]  len_st;
    logic [7:0]  b1, b2, b3;
    logic [15:0] tlen;
    logic [15:0] ident;

    function new();
      mismatches = 0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      nbytes = 0; kind = 0; hdr_byte = 0; len_val = 0; len_cnt = 0;
      len_st = mqtt_pkg::LenDecoding; b1 = 0; b2 = 0; b3 = 0; tlen = 0; ident = 0;
    endfunction

    function logic [1:0] len_fault(output bit hit);
      hit = 1;
      if (len_st == mqtt_pkg::LenDecoding) return mqtt_pkg::StIncomplete;
      if (len_st == mqtt_pkg::LenBad) return mqtt_pkg::StMalformed;
      hit = 0;
      return mqtt_pkg::StOk;
    endfunction

    function mqtt_pkg::result_t decide();
      mqtt_pkg::result_t r;
      longint rx, hl, plen, idx, rc;
      logic [1:0] qos;
      logic [1:0] e;
      bit hit;
      r = '0;
      r.status = mqtt_pkg::StMalformed;
      rx = nbytes;
      hl = 1 + len_cnt;
      plen = hl + len_val;
      case (kind)
        mqtt_pkg::KindPublish: begin
          qos = hdr_byte[2:1];
          if (rx < 2) return r;
          if (hdr_byte[7:4] != 4'h3) return r;
          if (qos == 2'd3) return r;
          e = len_fault(hit);
          if (hit) begin r.status = e; return r; end
          if (rx < plen) begin r.status = mqtt_pkg::StIncomplete; return r; end
          if (hl + 2 > plen) return r;
          idx = hl + 2;
          if (idx + tlen > plen) return r;
          r.topic_offset = 3'(idx);
          r.topic_bytes = tlen;
          idx += tlen;
          if (qos != 0) begin
            if (idx + 2 > plen) return r;
            r.msg_id = ident;
            idx += 2;
          end
          r.status = mqtt_pkg::StOk;
          r.dup_flag = hdr_byte[3];
          r.qos_level = qos;
          r.retain_flag = hdr_byte[0];
          r.body_offset = 17'(idx);
          r.body_len = 29'(plen - idx);
          r.frame_len = 29'(plen);
        end
        mqtt_pkg::KindConnack: begin
          if (rx < 4) begin r.status = mqtt_pkg::StIncomplete; return r; end
          if (hdr_byte != 8'h20 || b1 != 8'h02) return r;
          if (b2[7:1] != 0) return r;
          if (b3 != 0 && b2[0]) return r;
          r.status = mqtt_pkg::StOk;
          r.sess_flag = b2[0];
          r.ack_code = b3;
        end
        mqtt_pkg::KindSuback: begin
          if (rx < 2) begin r.status = mqtt_pkg::StIncomplete; return r; end
          if (hdr_byte != 8'h90) return r;
          e = len_fault(hit);
          if (hit) begin r.status = e; return r; end
          if (rx < plen) begin r.status = mqtt_pkg::StIncomplete; return r; end
          if (len_val < 3) return r;
          rc = plen - (hl + 2);
          if (rc == 0 || rc > 255) return r;
          r.status = mqtt_pkg::StOk;
          r.msg_id = ident;
          r.body_offset = 17'(hl + 2);
          r.body_len = 29'(rc);
          r.frame_len = 29'(plen);
        end
        mqtt_pkg::KindPuback: begin
          if (rx < 4) begin r.status = mqtt_pkg::StIncomplete; return r; end
          e = len_fault(hit);
          if (hit) begin r.status = e; return r; end
          if (hdr_byte != 8'h40) return r;
          if (len_val != 2 || len_cnt != 1) return r;
          r.status = mqtt_pkg::StOk;
          r.msg_id = ident;
        end
        mqtt_pkg::KindPingresp: begin
          if (rx < 2) begin r.status = mqtt_pkg::StIncomplete; return r; end
          e = len_fault(hit);
          if (hit) begin r.status = e; return r; end
          if (hdr_byte != 8'hD0 || len_val != 0 || len_cnt != 1) return r;
          r.status = mqtt_pkg::StOk;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_byte(logic [2:0] cmd, logic [7:0] b, logic last);
      longint pos, hl, p;
      logic [31:0] grp;
      pos = nbytes;
      if (pos == 0) begin kind = cmd; hdr_byte = b; end
      if (pos == 1) b1 = b;
      if (pos == 2) b2 = b;
      if (pos == 3) b3 = b;
      if (pos >= 1 && len_st == mqtt_pkg::LenDecoding) begin
        grp = {25'd0, b[6:0]} << (7 * len_cnt[1:0]);
        len_val = len_val | grp[27:0];
        len_cnt = len_cnt + 3'd1;
        if (!b[7]) len_st = mqtt_pkg::LenDone;
        else if (len_cnt >= mqtt_pkg::MaxLengthBytesDefault) len_st = mqtt_pkg::LenBad;
      end else if (pos >= 1 && len_st == mqtt_pkg::LenDone) begin
        hl = 1 + len_cnt;
        if (kind == mqtt_pkg::KindPublish) begin
          p = hl + 2 + tlen;
          if (pos == hl) tlen = {b, 8'h00};
          else if (pos == hl + 1) tlen = tlen | {8'h00, b};
          else if (pos == p) ident = {b, 8'h00};
          else if (pos == p + 1) ident = ident | {8'h00, b};
        end else begin
          if (pos == hl) ident = {b, 8'h00};
          else if (pos == hl + 1) ident = ident | {8'h00, b};
        end
      end
      if (nbytes != ByteCap) nbytes = nbytes + 32'd1;
      if (last) begin
        pending.push_back(decide());
        clear();
      end
    endfunction

    function void check_result(mqtt_pkg::result_t got);
      mqtt_pkg::result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        mismatches++;
        if (errors <= 10) $display("result mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;   // data_byte[7:0]
  logic [2:0] s_tuser;   // cmd[2:0]
  logic s_tlast;         // last_byte
  logic m_tvalid;
  logic m_tready;
  logic [127:0] m_tdata; // result fields from status upward

  parse_board board;
  bit quiet_tail;
  int hold_off;
  byte unsigned frame[$];

  mqtt_packet_header_parser_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic mqtt_pkg::result_t unpack_result(logic [127:0] d);
    mqtt_pkg::result_t u;
    u.status       = d[1:0];
    u.dup_flag     = d[2];
    u.qos_level    = d[4:3];
    u.retain_flag  = d[5];
    u.msg_id       = d[21:6];
    u.topic_offset = d[24:22];
    u.topic_bytes  = d[40:25];
    u.body_offset  = d[57:41];
    u.body_len     = d[86:58];
    u.frame_len    = d[115:87];
    u.sess_flag    = d[116];
    u.ack_code     = d[124:117];
    return u;
  endfunction

  // Send one byte; random gaps unless in the quiet tail.
  task automatic send_byte(logic [2:0] cmd, logic [7:0] b, logic last);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= cmd;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_byte(cmd, b, last);
  endtask

  task automatic send_frame(logic [2:0] cmd);
    for (int i = 0; i < frame.size(); i++)
      send_byte(cmd, frame[i], i == frame.size() - 1);
  endtask

  task automatic put_len(int v, int nb);
    for (int i = 0; i < nb; i++) begin
      frame.push_back(8'(((v >> (7 * i)) & 8'h7F) | ((i < nb - 1) ? 8'h80 : 8'h00)));
    end
  endtask

  // Build a mostly well-formed packet of the given kind, then maybe corrupt it.
  task automatic build_packet(logic [2:0] kind);
    int rl, tl, pl, nb, extra;
    logic [1:0] qos;
    frame.delete();
    nb = 1;
    case (kind)
      mqtt_pkg::KindPublish: begin
        qos = 2'($urandom_range(0, 2));
        tl = $urandom_range(0, 6);
        pl = $urandom_range(0, 8);
        rl = 2 + tl + (qos != 0 ? 2 : 0) + pl;
        if ($urandom_range(0, 9) == 0) nb = $urandom_range(1, 2);
        frame.push_back({4'h3, 1'($urandom), qos, 1'($urandom)});
        put_len(rl, nb);
        frame.push_back(8'h00);
        frame.push_back(8'(tl));
        repeat (tl) frame.push_back(8'($urandom));
        if (qos != 0) begin frame.push_back(8'($urandom)); frame.push_back(8'($urandom)); end
        repeat (pl) frame.push_back(8'($urandom));
      end
      mqtt_pkg::KindConnack: begin
        frame.push_back(8'h20); frame.push_back(8'h02);
        frame.push_back(8'($urandom_range(0, 1)));
        frame.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00);
      end
      mqtt_pkg::KindSuback: begin
        rl = 2 + $urandom_range(1, 6);
        frame.push_back(8'h90);
        put_len(rl, 1);
        repeat (rl) frame.push_back(8'($urandom));
      end
      mqtt_pkg::KindPuback: begin
        frame.push_back(8'h40); frame.push_back(8'h02);
        frame.push_back(8'($urandom)); frame.push_back(8'($urandom));
      end
      default: begin
        frame.push_back(8'hD0); frame.push_back(8'h00);
      end
    endcase
    extra = $urandom_range(0, 9);
    if (extra == 0) frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
    else if (extra == 1 && frame.size() > 1) frame.pop_back();
    else if (extra == 2) repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
  endtask

  // Drop the request and hold until every expected result has come.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off.
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_result(unpack_result(m_tdata));
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        hold_off = $urandom_range(0, 8);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    logic [2:0] k;
    board = new();
    quiet_tail = 0;
    hold_off = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one mostly well-formed packet per kind, unknown kinds, single bytes, long lengths.
    for (int i = 0; i < 5; i++) begin build_packet(3'(i)); send_frame(3'(i)); end
    frame = '{8'h30}; send_frame(mqtt_pkg::KindPublish);
    frame = '{8'hFF}; send_frame(3'd7);
    frame = '{8'h00, 8'h00}; send_frame(3'd5);
    frame = '{8'h36, 8'h02, 8'h00, 8'h00}; send_frame(mqtt_pkg::KindPublish);
    frame = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_frame(mqtt_pkg::KindPublish);
    frame = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'h7F}; send_frame(mqtt_pkg::KindPublish);
    frame = '{8'h20, 8'h02, 8'h01, 8'h05}; send_frame(mqtt_pkg::KindConnack);
    frame = '{8'h20, 8'h02, 8'hFE, 8'h00}; send_frame(mqtt_pkg::KindConnack);
    frame = '{8'h90, 8'h02, 8'h00, 8'h01}; send_frame(mqtt_pkg::KindSuback);
    frame = '{8'h40, 8'h82, 8'h00, 8'h00, 8'h00}; send_frame(mqtt_pkg::KindPuback);
    frame = '{8'hD0, 8'h80, 8'h00}; send_frame(mqtt_pkg::KindPingresp);
    wait_drained();

    // Long receiver hold-off while the sender keeps pushing.
    hold_off = 300;
    for (int i = 0; i < 20; i++) begin
      frame = '{8'hD0, 8'h00}; send_frame(mqtt_pkg::KindPingresp);
    end
    wait_drained();

    n = 0;
    while (n < 1850) begin
      if (n > 1600) quiet_tail = 1;
      if ($urandom_range(0, 9) == 0) begin
        frame.delete();
        repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
        k = 3'($urandom);
      end else begin
        k = 3'($urandom_range(0, 4));
        build_packet(k);
        if ($urandom_range(0, 19) == 0) k = 3'($urandom_range(0, 4));
      end
      send_frame(k);
      n += frame.size();
      if ($urandom_range(0, 60) == 0) wait_drained();
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (board.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
